// ===== rtl/core/owmk_pkg.sv =====
`default_nettype none
package owmk_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int COS45_Q16  = 46341;

    localparam int IN_W       = 16;
    localparam int PULSE_W    = 12;
    localparam int OFS_W      = 10;
    // signed wheel value: three terms of at most 2^31 each
    localparam int WHEEL_W    = 34;
    localparam int MAG_W      = WHEEL_W - 1;
    localparam int PROD_W     = MAG_W + OFS_W;
    localparam int QUOT_W     = OFS_W;
    localparam int QBIT_W     = $clog2(QUOT_W);
    localparam int N_WHEELS   = 4;
    localparam int WIDX_W     = $clog2(N_WHEELS);
    localparam int Q_DEPTH    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KICK     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = CFG_IDX_W'(3);

    localparam logic [PULSE_W-1:0] RST_NEUTRAL  = PULSE_W'(1490);
    localparam logic [OFS_W-1:0]   RST_DEADZONE = OFS_W'(60);
    localparam logic [OFS_W-1:0]   RST_KICK     = OFS_W'(200);
    localparam logic [OFS_W-1:0]   RST_GAIN     = OFS_W'(150);

    localparam logic [MAG_W-1:0]   UNIT_MAG  = MAG_W'(1) << (FRAC_BITS + 16);
    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd3
    } t_dir;

    typedef struct packed {
        logic [PULSE_W-1:0] neutral_pulse;
        logic [OFS_W-1:0]   run_offset;
        logic [OFS_W-1:0]   kick_offset;
        logic [OFS_W-1:0]   speed_gain;
    } t_cfg;

    typedef struct packed {
        logic [N_WHEELS-1:0][MAG_W-1:0] mag;
        logic [N_WHEELS-1:0]            neg;
        logic [MAG_W-1:0]               den;
        logic                           scaled;
    } t_mix_item;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_MIX,
        F_MAX,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_PULSE,
        B_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/core/owmk_stream_if.sv =====
`default_nettype none
interface owmk_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [owmk_pkg::IN_W-1:0]    vel_x;
    logic signed [owmk_pkg::IN_W-1:0]    vel_y;
    logic signed [owmk_pkg::IN_W-1:0]    turn_rate;

    modport source (output valid, vel_x, vel_y, turn_rate, input ready);
    modport sink   (input valid, vel_x, vel_y, turn_rate, output ready);
endinterface

interface owmk_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [owmk_pkg::PULSE_W-1:0]  pulse_front_right;
    logic [owmk_pkg::PULSE_W-1:0]  pulse_front_left;
    logic [owmk_pkg::PULSE_W-1:0]  pulse_rear_left;
    logic [owmk_pkg::PULSE_W-1:0]  pulse_rear_right;
    logic                          was_scaled;

    modport source (output valid, pulse_front_right, pulse_front_left, pulse_rear_left,
                    pulse_rear_right, was_scaled, input ready);
    modport sink   (input valid, pulse_front_right, pulse_front_left, pulse_rear_left,
                    pulse_rear_right, was_scaled, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/owmk_front.sv =====
`default_nettype none
module owmk_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    owmk_cmd_if.sink                 i_cmd,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output owmk_pkg::t_mix_item      o_q_item
);

    localparam int WW = owmk_pkg::WHEEL_W;
    localparam int MW = owmk_pkg::MAG_W;
    localparam int NW = owmk_pkg::N_WHEELS;
    localparam logic signed [WW-1:0] C_COS = WW'(owmk_pkg::COS45_Q16);

    owmk_pkg::t_front_state r_state, n_state;

    logic signed [WW-1:0] r_a, r_b, r_w;
    logic [NW-1:0][MW-1:0] r_mag;
    logic [NW-1:0]         r_neg;
    logic [MW-1:0]         r_max01, r_max23;

    logic signed [WW-1:0] wh [NW];
    logic [MW-1:0]        mx;
    logic                 accept;

    assign accept = i_cmd.valid && i_cmd.ready;

    // wheel mix: motor zero (front right) negated
    always_comb begin
        wh[0] = r_b - r_a - r_w;
        wh[1] = r_a + r_b - r_w;
        wh[2] = r_b - r_a - r_w;
        wh[3] = r_w - r_a - r_b;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            owmk_pkg::F_IDLE: if (i_cmd.valid) n_state = owmk_pkg::F_MUL;
            owmk_pkg::F_MUL:  n_state = owmk_pkg::F_MIX;
            owmk_pkg::F_MIX:  n_state = owmk_pkg::F_MAX;
            owmk_pkg::F_MAX:  n_state = owmk_pkg::F_PUSH;
            owmk_pkg::F_PUSH: if (!i_q_full) n_state = owmk_pkg::F_IDLE;
            default:          n_state = owmk_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_cmd.ready = 1'b0;
        o_q_push    = 1'b0;
        case (r_state)
            owmk_pkg::F_IDLE: i_cmd.ready = 1'b1;
            owmk_pkg::F_PUSH: o_q_push    = !i_q_full;
            default: begin
                i_cmd.ready = 1'b0;
                o_q_push    = 1'b0;
            end
        endcase
    end

    always_comb begin
        mx              = (r_max01 > r_max23) ? r_max01 : r_max23;
        o_q_item.mag    = r_mag;
        o_q_item.neg    = r_neg;
        o_q_item.scaled = mx > owmk_pkg::UNIT_MAG;
        o_q_item.den    = o_q_item.scaled ? mx : owmk_pkg::UNIT_MAG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= owmk_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= WW'(i_cmd.vel_x) * C_COS;
            r_b <= WW'(i_cmd.vel_y) * C_COS;
            r_w <= WW'($signed({i_cmd.turn_rate, 16'b0}));
        end
        if (r_state == owmk_pkg::F_MIX) begin
            for (int i = 0; i < NW; i++) begin
                r_neg[i] <= wh[i][WW-1];
                r_mag[i] <= wh[i][WW-1] ? MW'(-wh[i]) : MW'(wh[i]);
            end
        end
        if (r_state == owmk_pkg::F_MAX) begin
            r_max01 <= (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
            r_max23 <= (r_mag[2] > r_mag[3]) ? r_mag[2] : r_mag[3];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/owmk_queue.sv =====
`default_nettype none
module owmk_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire owmk_pkg::t_mix_item i_item,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output owmk_pkg::t_mix_item      o_item
);

    localparam int DEPTH = owmk_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    owmk_pkg::t_mix_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("item pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("item popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("queue count out of range");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ===== rtl/core/owmk_back.sv =====
`default_nettype none
module owmk_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire owmk_pkg::t_cfg      i_cfg,
    input  wire logic                i_q_valid,
    input  wire owmk_pkg::t_mix_item i_q_item,
    output logic                     o_q_pop,
    owmk_pulse_if.source             o_pulse
);

    localparam int NW  = owmk_pkg::N_WHEELS;
    localparam int PW  = owmk_pkg::PULSE_W;
    localparam int OW  = owmk_pkg::OFS_W;
    localparam int PRW = owmk_pkg::PROD_W;
    localparam int QW  = owmk_pkg::QUOT_W;
    localparam int QBW = owmk_pkg::QBIT_W;
    localparam int IW  = owmk_pkg::WIDX_W;

    owmk_pkg::t_back_state r_state, n_state;

    logic [IW-1:0]   r_idx;
    logic [PRW-1:0]  r_rem;
    logic [QW-1:0]   r_quot;
    logic [QBW-1:0]  r_bit;
    owmk_pkg::t_dir  r_dir [NW];
    logic [PW-1:0]   r_pulse [NW];

    logic            r_out_valid;
    logic [PW-1:0]   r_out_pulse [NW];
    logic            r_out_scaled;

    logic [PRW-1:0]  shifted;
    logic            fits;
    logic            out_free;
    logic            load_out;
    logic            last_wheel;
    logic [OW-1:0]   off;
    logic [OW:0]     mag_ofs;
    logic [PW:0]     up;
    logic [PW-1:0]   pulse;
    owmk_pkg::t_dir  cur;

    assign shifted    = PRW'(i_q_item.den) << r_bit;
    assign fits       = r_rem >= shifted;
    assign out_free   = !r_out_valid || o_pulse.ready;
    assign last_wheel = (r_idx == IW'(NW - 1));

    // offset away from neutral, the kick offset when the wheel was at rest
    always_comb begin
        off     = (r_dir[r_idx] == owmk_pkg::DIR_STOP) ? i_cfg.kick_offset
                                                       : i_cfg.run_offset;
        mag_ofs = {1'b0, r_quot} + {1'b0, off};
        up      = {1'b0, i_cfg.neutral_pulse} + (PW + 1)'(mag_ofs);
        if (r_quot == '0) begin
            cur   = owmk_pkg::DIR_STOP;
            pulse = i_cfg.neutral_pulse;
        end else if (i_q_item.neg[r_idx]) begin
            cur   = owmk_pkg::DIR_REV;
            pulse = (i_cfg.neutral_pulse < PW'(mag_ofs)) ? '0
                    : i_cfg.neutral_pulse - PW'(mag_ofs);
        end else begin
            cur   = owmk_pkg::DIR_FWD;
            pulse = up[PW] ? owmk_pkg::PULSE_MAX : up[PW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            owmk_pkg::B_IDLE:  if (i_q_valid) n_state = owmk_pkg::B_MUL;
            owmk_pkg::B_MUL:   n_state = owmk_pkg::B_DIV;
            owmk_pkg::B_DIV:   if (r_bit == '0) n_state = owmk_pkg::B_PULSE;
            owmk_pkg::B_PULSE: n_state = last_wheel ? owmk_pkg::B_OUT : owmk_pkg::B_MUL;
            owmk_pkg::B_OUT:   if (out_free) n_state = owmk_pkg::B_IDLE;
            default:           n_state = owmk_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        load_out = 1'b0;
        o_q_pop  = 1'b0;
        case (r_state)
            owmk_pkg::B_OUT: begin
                load_out = out_free;
                o_q_pop  = out_free;
            end
            default: begin
                load_out = 1'b0;
                o_q_pop  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= owmk_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < NW; i++) begin
                r_dir[i] <= owmk_pkg::DIR_STOP;
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_pulse.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == owmk_pkg::B_IDLE) begin
                r_idx <= '0;
            end else if (r_state == owmk_pkg::B_PULSE) begin
                r_dir[r_idx] <= cur;
                r_idx        <= r_idx + IW'(1);
            end
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            owmk_pkg::B_MUL: begin
                r_rem  <= PRW'(i_q_item.mag[r_idx]) * PRW'(i_cfg.speed_gain);
                r_quot <= '0;
                r_bit  <= QBW'(QW - 1);
            end
            owmk_pkg::B_DIV: begin
                if (fits) begin
                    r_rem         <= r_rem - shifted;
                    r_quot[r_bit] <= 1'b1;
                end
                r_bit <= r_bit - QBW'(1);
            end
            owmk_pkg::B_PULSE: begin
                r_pulse[r_idx] <= pulse;
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
        if (load_out) begin
            for (int i = 0; i < NW; i++) begin
                r_out_pulse[i] <= r_pulse[i];
            end
            r_out_scaled <= i_q_item.scaled;
        end
    end

    assign o_pulse.valid             = r_out_valid;
    assign o_pulse.pulse_front_right = r_out_pulse[0];
    assign o_pulse.pulse_front_left  = r_out_pulse[1];
    assign o_pulse.pulse_rear_left   = r_out_pulse[2];
    assign o_pulse.pulse_rear_right  = r_out_pulse[3];
    assign o_pulse.was_scaled        = r_out_scaled;

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == owmk_pkg::B_PULSE) |-> (r_quot <= i_cfg.speed_gain))
        else $error("wheel deviation exceeds gain");

endmodule
`default_nettype wire

// ===== rtl/core/omni_wheel_mixer_kickstart_top.sv =====
`default_nettype none
// Four-wheel omni mixer: takes one motion command (vel_x, vel_y, turn_rate in
// signed Q3.12) and returns four ESC pulse widths plus a flag that says whether
// the wheel speeds were normalized by their maximum. Each wheel gets a kick
// offset when it starts from rest and a deadzone offset while it keeps moving;
// the per-wheel direction is kept from one command to the next and cleared by
// reset. The command rate is set by the back end, which runs all four wheels
// in turn through one shared multiplier and one restoring divider (per wheel a
// multiply state, the divide state once per quotient bit and a pulse state, plus
// a hand-off state). The front end mixes and finds the maximum in its MUL, MIX
// and MAX states and works ahead through a two-entry queue, so it can accept a
// new command while the back end is still busy and the queue has room.
// Write configuration only while no command is in flight.
module omni_wheel_mixer_kickstart_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [owmk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [owmk_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    owmk_cmd_if.sink                                i_cmd,
    owmk_pulse_if.source                            o_pulse
);

    localparam int PW = owmk_pkg::PULSE_W;
    localparam int OW = owmk_pkg::OFS_W;

    owmk_pkg::t_cfg      r_cfg;
    owmk_pkg::t_mix_item push_item, head_item;
    logic                push, full, head_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_pulse <= owmk_pkg::RST_NEUTRAL;
            r_cfg.run_offset    <= owmk_pkg::RST_DEADZONE;
            r_cfg.kick_offset   <= owmk_pkg::RST_KICK;
            r_cfg.speed_gain    <= owmk_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owmk_pkg::CFG_NEUTRAL:  r_cfg.neutral_pulse <= i_cfg_data[PW-1:0];
                owmk_pkg::CFG_DEADZONE: r_cfg.run_offset    <= i_cfg_data[OW-1:0];
                owmk_pkg::CFG_KICK:     r_cfg.kick_offset   <= i_cfg_data[OW-1:0];
                owmk_pkg::CFG_GAIN:     r_cfg.speed_gain    <= i_cfg_data[OW-1:0];
                default:                r_cfg               <= r_cfg;
            endcase
        end
    end

    owmk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (full),
        .o_q_push (push),
        .o_q_item (push_item)
    );

    owmk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    owmk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (head_valid),
        .i_q_item  (head_item),
        .o_q_pop   (pop),
        .o_pulse   (o_pulse)
    );

endmodule
`default_nettype wire

// ===== tb/owmk_mixer_monitor.sv =====
module owmk_mixer_monitor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [owmk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [owmk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    owmk_cmd_if                                  cmd_ch,
    owmk_pulse_if                                pulse_ch,
    output int                                   o_mismatches,
    output int                                   o_pending
);
    import owmk_pkg::*;

    typedef struct packed {
        logic [PULSE_W-1:0] front_right;
        logic [PULSE_W-1:0] front_left;
        logic [PULSE_W-1:0] rear_left;
        logic [PULSE_W-1:0] rear_right;
        logic               was_scaled;
    } pulse_set_t;

    t_cfg       mixer_regs;
    t_dir       wheel_dir [N_WHEELS];
    pulse_set_t pending_pulses [$];

    // Mix one command into four pulses and update the stored wheel directions.
    function automatic pulse_set_t mix_command(input logic signed [IN_W-1:0] vx,
                                               input logic signed [IN_W-1:0] vy,
                                               input logic signed [IN_W-1:0] om);
        longint     term_x, term_y, term_w, unit, peak, den, dev, off, pulse;
        longint     neutral, deadzone, kick, gain;
        longint     wheel [N_WHEELS];
        longint     mag;
        pulse_set_t res;
        logic [PULSE_W-1:0] pw [N_WHEELS];

        neutral  = longint'(mixer_regs.neutral_pulse);
        deadzone = longint'(mixer_regs.run_offset);
        kick     = longint'(mixer_regs.kick_offset);
        gain     = longint'(mixer_regs.speed_gain);

        term_x = longint'(vx) * COS45_Q16;
        term_y = longint'(vy) * COS45_Q16;
        term_w = longint'(om) * 65536;
        wheel[0] = -(term_x - term_y + term_w);
        wheel[1] = term_x + term_y - term_w;
        wheel[2] = -term_x + term_y - term_w;
        wheel[3] = -term_x - term_y + term_w;

        peak = 0;
        for (int i = 0; i < N_WHEELS; i++) begin
            mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
            if (mag > peak) peak = mag;
        end
        unit = longint'(1) << (FRAC_BITS + 16);
        res.was_scaled = (peak > unit);
        den = res.was_scaled ? peak : unit;

        for (int i = 0; i < N_WHEELS; i++) begin
            dev = (wheel[i] * gain) / den;
            if (dev == 0) begin
                pulse = neutral;
            end else begin
                // a wheel leaving rest gets the kick offset
                off   = (wheel_dir[i] == DIR_STOP) ? kick : deadzone;
                pulse = neutral + dev + ((dev > 0) ? off : -off);
            end
            if (pulse < 0) pulse = 0;
            if (pulse > 4095) pulse = 4095;
            pw[i] = pulse[PULSE_W-1:0];
            wheel_dir[i] = (dev > 0) ? DIR_FWD : ((dev < 0) ? DIR_REV : DIR_STOP);
        end

        res.front_right = pw[0];
        res.front_left  = pw[1];
        res.rear_left   = pw[2];
        res.rear_right  = pw[3];
        return res;
    endfunction

    function automatic int field_wrong(input string name, input logic [PULSE_W-1:0] want,
                                       input logic [PULSE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        pulse_set_t want;
        int         bad;

        if (!i_rst_n) begin
            mixer_regs.neutral_pulse = RST_NEUTRAL;
            mixer_regs.run_offset    = RST_DEADZONE;
            mixer_regs.kick_offset   = RST_KICK;
            mixer_regs.speed_gain    = RST_GAIN;
            for (int i = 0; i < N_WHEELS; i++) wheel_dir[i] = DIR_STOP;
            pending_pulses.delete();
            o_mismatches = 0;
        end else begin
            if (pulse_ch.valid && pulse_ch.ready) begin
                if (pending_pulses.size() == 0) begin
                    $display("%0t: pulse item expected none, got %0d %0d %0d %0d scaled %0d",
                             $time, pulse_ch.pulse_front_right, pulse_ch.pulse_front_left,
                             pulse_ch.pulse_rear_left, pulse_ch.pulse_rear_right,
                             pulse_ch.was_scaled);
                    o_mismatches++;
                end else begin
                    want = pending_pulses.pop_front();
                    bad = field_wrong("pulse_front_right", want.front_right,
                                      pulse_ch.pulse_front_right)
                        + field_wrong("pulse_front_left", want.front_left,
                                      pulse_ch.pulse_front_left)
                        + field_wrong("pulse_rear_left", want.rear_left,
                                      pulse_ch.pulse_rear_left)
                        + field_wrong("pulse_rear_right", want.rear_right,
                                      pulse_ch.pulse_rear_right)
                        + field_wrong("was_scaled", PULSE_W'(want.was_scaled),
                                      PULSE_W'(pulse_ch.was_scaled));
                    if (bad != 0) o_mismatches++;
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                pending_pulses.push_back(mix_command(cmd_ch.vel_x, cmd_ch.vel_y,
                                                     cmd_ch.turn_rate));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NEUTRAL:  mixer_regs.neutral_pulse = i_cfg_data[PULSE_W-1:0];
                    CFG_DEADZONE: mixer_regs.run_offset    = i_cfg_data[OFS_W-1:0];
                    CFG_KICK:     mixer_regs.kick_offset   = i_cfg_data[OFS_W-1:0];
                    CFG_GAIN:     mixer_regs.speed_gain    = i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_pulses.size();
    end

endmodule

// ===== tb/omni_wheel_mixer_kickstart_top_tb.sv =====
module omni_wheel_mixer_kickstart_top_tb;
    import owmk_pkg::*;

    localparam int ITEMS_PER_PHASE = 238;
    localparam int N_DIRECTED      = 22;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 60;

    // vel_x, vel_y, turn_rate
    localparam logic [3*IN_W-1:0] DIRECTED [N_DIRECTED] = '{
        {16'sd0,      16'sd0,      16'sd0},
        {16'sd4096,   16'sd0,      16'sd0},
        {16'sd4096,   16'sd0,      16'sd0},
        {-16'sd4096,  16'sd0,      16'sd0},
        {16'sd0,      16'sd0,      16'sd0},
        {16'sd2896,   16'sd2896,   16'sd0},
        {16'sd0,      16'sd0,      16'sd4096},
        {16'sd0,      16'sd0,      16'sd4097},
        {16'sd0,      16'sd4096,   16'sd0},
        {16'sd0,      16'sd0,      -16'sd4096},
        {16'sd38,     16'sd0,      16'sd0},
        {16'sd39,     16'sd0,      16'sd0},
        {-16'sd39,    16'sd0,      16'sd0},
        {16'sd1,      16'sd0,      16'sd0},
        {16'sd0,      16'sd0,      16'sd1},
        {16'sh7FFF,   16'sh7FFF,   16'sh7FFF},
        {16'sh8000,   16'sh8000,   16'sh8000},
        {16'sh7FFF,   16'sh8000,   16'sd0},
        {16'sh8000,   16'sh7FFF,   16'sh8000},
        {16'sd0,      16'sd0,      16'sd0},
        {-16'sd1,     -16'sd1,     -16'sd1},
        {16'sd0,      16'sd0,      16'sd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int holds_requested;
    int cmds_sent;
    int settings_used;
    int quiet_cycles;
    int mismatches;
    int pending;

    logic signed [IN_W-1:0] last_vx, last_vy, last_om;

    owmk_cmd_if   cmd_ch ();
    owmk_pulse_if pulse_ch ();

    omni_wheel_mixer_kickstart_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_ch),
        .o_pulse    (pulse_ch)
    );

    owmk_mixer_monitor mixer_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .cmd_ch       (cmd_ch),
        .pulse_ch     (pulse_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial begin : receiver
        int holds_served;
        int hold_left;

        holds_served = 0;
        hold_left = 0;
        pulse_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != holds_requested) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pulse_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                pulse_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (pulse_ch.valid && pulse_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [IN_W-1:0] spread(input int span);
        return IN_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Call at a falling edge; leaves valid high so back-to-back items need no gap.
    task automatic send_cmd(input logic signed [IN_W-1:0] vx,
                            input logic signed [IN_W-1:0] vy,
                            input logic signed [IN_W-1:0] om);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.vel_x     <= vx;
        cmd_ch.vel_y     <= vy;
        cmd_ch.turn_rate <= om;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
        cmds_sent++;
    endtask

    task automatic send_random_cmds(input int count);
        logic signed [IN_W-1:0] vx, vy, om, axis_val;

        repeat (count) begin
            vx = '0;
            vy = '0;
            om = '0;
            case ($urandom_range(9))
                0, 1, 2: begin
                    vx = IN_W'($urandom);
                    vy = IN_W'($urandom);
                    om = IN_W'($urandom);
                end
                3, 4, 5: begin
                    vx = spread(2400);
                    vy = spread(2400);
                    om = spread(2400);
                end
                6: ;
                7: begin
                    vx = spread(60);
                    vy = spread(60);
                    om = spread(60);
                end
                8: begin
                    axis_val = IN_W'(int'($urandom_range(65535)) - 32768);
                    case ($urandom_range(2))
                        0: vx = axis_val;
                        1: vy = axis_val;
                        default: om = axis_val;
                    endcase
                end
                default: begin
                    // keep the wheels running with the previous command
                    vx = last_vx;
                    vy = last_vy;
                    om = last_om;
                end
            endcase
            last_vx = vx;
            last_vy = vy;
            last_om = om;
            send_cmd(vx, vy, om);
        end
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // Write all four registers and one unused index, which must be dropped.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] neutral,
                                  input logic [CFG_DATA_W-1:0] deadzone,
                                  input logic [CFG_DATA_W-1:0] kick,
                                  input logic [CFG_DATA_W-1:0] gain);
        logic [CFG_IDX_W-1:0] spare_idx;

        spare_idx = CFG_IDX_W'(CFG_GAIN + 1 + $urandom_range(3));
        put_reg(CFG_NEUTRAL, neutral);
        put_reg(CFG_DEADZONE, deadzone);
        put_reg(spare_idx, CFG_DATA_W'($urandom));
        put_reg(CFG_KICK, kick);
        put_reg(CFG_GAIN, gain);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.vel_x     = '0;
        cmd_ch.vel_y     = '0;
        cmd_ch.turn_rate = '0;
        send_idle_pct    = 20;
        recv_idle_pct    = 74;
        holds_requested  = 0;
        cmds_sent        = 0;
        settings_used    = 1;
        last_vx          = '0;
        last_vy          = '0;
        last_om          = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: directed commands first
        for (int i = 0; i < N_DIRECTED; i++)
            send_cmd(DIRECTED[i][3*IN_W-1:2*IN_W], DIRECTED[i][2*IN_W-1:IN_W],
                     DIRECTED[i][IN_W-1:0]);
        send_random_cmds(ITEMS_PER_PHASE - N_DIRECTED);

        wait_for_results();
        write_settings(12'd1500, 12'd0, 12'd0, 12'hFFF);
        send_random_cmds(ITEMS_PER_PHASE);

        // neutral at zero drives reverse wheels into the low clamp
        wait_for_results();
        write_settings(12'd0, 12'hFFF, 12'hFFF, 12'hFFF);
        send_random_cmds(ITEMS_PER_PHASE);

        wait_for_results();
        send_idle_pct = 74;
        recv_idle_pct = 20;
        write_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_random_cmds(ITEMS_PER_PHASE);

        // zero gain: every wheel stays at neutral
        wait_for_results();
        write_settings(12'd1490, 12'd60, 12'd200, 12'd0);
        send_random_cmds(ITEMS_PER_PHASE);

        wait_for_results();
        write_settings(12'd2048, 12'd5, 12'd300, 12'd1);
        send_random_cmds(ITEMS_PER_PHASE);

        // back-pressure: stall the output while commands keep coming
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings(12'd1490, 12'd60, 12'd200, 12'd150);
        holds_requested++;
        send_random_cmds(ITEMS_PER_PHASE);

        wait_for_results();
        write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1023)),
                       CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)));
        send_random_cmds(ITEMS_PER_PHASE);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Mixed %0d motion commands under %0d register settings,", cmds_sent,
                 settings_used);
        $display("with both-side stalls, saturation, zero gain and a long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d pulse items did not match", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== omni_wheel_mixer_kickstart_top.f =====
rtl/core/owmk_pkg.sv
rtl/core/owmk_stream_if.sv
rtl/core/owmk_front.sv
rtl/core/owmk_queue.sv
rtl/core/owmk_back.sv
rtl/core/omni_wheel_mixer_kickstart_top.sv
tb/owmk_mixer_monitor.sv
tb/omni_wheel_mixer_kickstart_top_tb.sv
